// ===== rtl/core/maze_all_paths_search_macros.svh =====
// Assertion macros for the maze all-paths search core.
// Included by modules that check their own sequencing; needs i_clk and i_rst_n in scope.
`ifndef MAZE_ALL_PATHS_SEARCH_MACROS_SVH
`define MAZE_ALL_PATHS_SEARCH_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define MAPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition implies a second one in the following cycle.
`define MAPS_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/maps_pkg.sv =====
// Shared types, sizes and helper functions for the maze all-paths search core.
// No dependencies; imported by maze_all_paths_search.
package maps_pkg;

    localparam int GRID_ROWS   = 16;
    localparam int GRID_COLS   = 16;
    localparam int STACK_DEPTH = 64;

    localparam int FIELD_W = 4;
    localparam int COUNT_W = 16;
    localparam int LEN_W   = 7;
    localparam int LEN_MAX = (1 << LEN_W) - 1;

    localparam int CELLS  = GRID_ROWS * GRID_COLS;
    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam int FILL_W = $clog2(STACK_DEPTH + 2);
    localparam int DIR_W  = 3;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        CELL_OPEN = 2'd0,
        CELL_WALL = 2'd1,
        CELL_PATH = 2'd2
    } t_cell;

    typedef enum logic [DIR_W-1:0] {
        DIR_UP    = 3'd0,
        DIR_RIGHT = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_DONE  = 3'd4
    } t_dir;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START_RD,
        S_START_CHK,
        S_EXAMINE,
        S_NB_CHK,
        S_POP,
        S_RESTORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        t_dir             dir;
    } t_frame;

    typedef struct packed {
        logic               command;
        logic [FIELD_W-1:0] cell_row;
        logic [FIELD_W-1:0] cell_col;
        logic               cell_blocked;
        logic [FIELD_W-1:0] start_row;
        logic [FIELD_W-1:0] start_col;
        logic [FIELD_W-1:0] exit_row;
        logic [FIELD_W-1:0] exit_col;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] path_count;
        logic [LEN_W-1:0]   shortest_length;
        logic [COUNT_W-1:0] shortest_order;
        logic               stack_overflow;
    } t_out_item;

    // Linear grid address of a cell, row major.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(GRID_COLS);
        return base + ADDR_W'(col);
    endfunction

endpackage

// ===== rtl/core/maze_all_paths_search.sv =====
// Maze all-paths search core: grid memory, path stack memory and the walk sequencer.
// Depends on maps_pkg and maze_all_paths_search_macros.svh.
//
// This block holds a GRID_ROWS x GRID_COLS maze and counts every simple path from a
// start cell to an exit cell by depth-first backtracking. A load transaction
// (command 0) writes one cell as open or wall; cells that were
// never loaded read as walls, and no result is returned for a load. A search
// transaction (command 1) walks the maze, trying up, right, down and left in that
// order, and returns one result transaction: whether the exit was reached, the
// saturating path count, the cell count of the first shortest path with its order
// number, and a flag that is set when a push was refused because the path stack of
// STACK_DEPTH cells was full. The input side stalls for the whole search. After a
// search is accepted, the start cell is read and then checked. Every direction tried
// from a cell then has its neighbor address issued, then the registered grid read
// examined. Every backtrack finds the cell finished or at the exit, releases it, then
// reads the parent frame back from the stack memory; the last backtrack, off the
// start cell, skips that read. A done state then hands off the result. The grid
// and stack memories have registered reads. The top of the path stack lives in
// registers so that only the frames below it sit in memory. A finished result waits
// in an output register until taken, and the next transaction is accepted meanwhile;
// only a second search result must wait for it.
module maze_all_paths_search
    import maps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    // Sequencer and search bookkeeping.
    t_state             r_state, n_state;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [COUNT_W-1:0] r_paths, n_paths;
    logic [FILL_W-1:0]  r_best_len, n_best_len;
    logic [COUNT_W-1:0] r_best_order, n_best_order;
    logic               r_ovf, n_ovf;

    // Search operands and the frame at the top of the stack.
    logic [FIELD_W-1:0] r_start_row, n_start_row;
    logic [FIELD_W-1:0] r_start_col, n_start_col;
    logic [FIELD_W-1:0] r_exit_row, n_exit_row;
    logic [FIELD_W-1:0] r_exit_col, n_exit_col;
    t_frame             r_top, n_top;
    logic [ROW_W-1:0]   r_nb_row, n_nb_row;
    logic [COL_W-1:0]   r_nb_col, n_nb_col;
    logic               r_nb_in, n_nb_in;

    // Result register.
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out_item, n_out_item;

    // Grid memory with one valid bit per cell; an invalid cell reads as a wall.
    t_cell              r_grid [CELLS];
    logic [CELLS-1:0]   r_cell_vld;
    t_cell              r_rd_data;
    logic               r_rd_vld;
    logic               grid_we;
    logic [ADDR_W-1:0]  grid_wa;
    t_cell              grid_wd;
    logic [ADDR_W-1:0]  grid_ra;

    // Stack memory for the frames below the top.
    t_frame             r_stack [STACK_DEPTH];
    t_frame             r_stk_rd;
    logic               stk_we;
    logic [SP_W-1:0]    stk_wa;
    logic [SP_W-1:0]    stk_ra;

    // Shared compare and step results.
    logic               in_accept;
    logic               is_search;
    logic               load_in_grid;
    logic               start_in_grid;
    logic               start_open;
    logic               at_exit;
    logic               nb_open;
    logic               stack_room;
    logic               out_free;
    logic [FILL_W-1:0]  fill_m1;
    logic [FILL_W-1:0]  fill_m2;
    logic [COUNT_W-1:0] paths_inc;
    logic               step_in;
    logic [ROW_W-1:0]   step_row;
    logic [COL_W-1:0]   step_col;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign is_search   = (i_in_item.command == CMD_SEARCH);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign load_in_grid  = (int'(i_in_item.cell_row) < GRID_ROWS) &&
                           (int'(i_in_item.cell_col) < GRID_COLS);
    assign start_in_grid = (int'(r_start_row) < GRID_ROWS) && (int'(r_start_col) < GRID_COLS);
    assign start_open    = start_in_grid && r_rd_vld && (r_rd_data == CELL_OPEN);
    assign nb_open       = r_nb_in && r_rd_vld && (r_rd_data == CELL_OPEN);
    assign at_exit       = (int'(r_top.row) == int'(r_exit_row)) &&
                           (int'(r_top.col) == int'(r_exit_col));
    assign stack_room    = (int'(r_fill) < STACK_DEPTH);
    assign fill_m1       = r_fill - FILL_W'(1);
    assign fill_m2       = r_fill - FILL_W'(2);
    assign paths_inc     = (r_paths == '1) ? r_paths : r_paths + COUNT_W'(1);

    // Neighbor of the top cell in the direction under test; off-grid means wall.
    always_comb begin
        step_row = r_top.row;
        step_col = r_top.col;
        step_in  = 1'b0;
        case (r_top.dir)
            DIR_UP: begin
                step_row = r_top.row - ROW_W'(1);
                step_in  = (r_top.row != '0);
            end
            DIR_RIGHT: begin
                step_col = r_top.col + COL_W'(1);
                step_in  = (int'(r_top.col) != GRID_COLS - 1);
            end
            DIR_DOWN: begin
                step_row = r_top.row + ROW_W'(1);
                step_in  = (int'(r_top.row) != GRID_ROWS - 1);
            end
            DIR_LEFT: begin
                step_col = r_top.col - COL_W'(1);
                step_in  = (r_top.col != '0);
            end
            default: begin
                step_in = 1'b0;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && is_search) begin
                    n_state = S_START_RD;
                end
            end
            S_START_RD: begin
                n_state = S_START_CHK;
            end
            S_START_CHK: begin
                n_state = start_open ? S_EXAMINE : S_DONE;
            end
            S_EXAMINE: begin
                if (at_exit || (r_top.dir == DIR_DONE)) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_NB_CHK;
                end
            end
            S_NB_CHK: begin
                n_state = S_EXAMINE;
            end
            S_POP: begin
                n_state = (fill_m1 == '0) ? S_DONE : S_RESTORE;
            end
            S_RESTORE: begin
                n_state = S_EXAMINE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath control and next register values.
    always_comb begin
        n_fill       = r_fill;
        n_paths      = r_paths;
        n_best_len   = r_best_len;
        n_best_order = r_best_order;
        n_ovf        = r_ovf;
        n_start_row  = r_start_row;
        n_start_col  = r_start_col;
        n_exit_row   = r_exit_row;
        n_exit_col   = r_exit_col;
        n_top        = r_top;
        n_nb_row     = r_nb_row;
        n_nb_col     = r_nb_col;
        n_nb_in      = r_nb_in;
        n_out_item   = r_out_item;
        n_out_valid  = r_out_valid && i_out_stall;
        grid_we      = 1'b0;
        grid_wa      = cell_addr(r_top.row, r_top.col);
        grid_wd      = CELL_OPEN;
        grid_ra      = cell_addr(step_row, step_col);
        stk_we       = 1'b0;
        stk_wa       = fill_m1[SP_W-1:0];
        stk_ra       = fill_m2[SP_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_accept && !is_search) begin
                    grid_we = load_in_grid;
                    grid_wa = cell_addr(ROW_W'(i_in_item.cell_row), COL_W'(i_in_item.cell_col));
                    grid_wd = i_in_item.cell_blocked ? CELL_WALL : CELL_OPEN;
                end else if (in_accept) begin
                    n_start_row  = i_in_item.start_row;
                    n_start_col  = i_in_item.start_col;
                    n_exit_row   = i_in_item.exit_row;
                    n_exit_col   = i_in_item.exit_col;
                    n_fill       = '0;
                    n_paths      = '0;
                    n_best_len   = FILL_W'(STACK_DEPTH + 1);
                    n_best_order = '0;
                    n_ovf        = 1'b0;
                end
            end
            S_START_RD: begin
                grid_ra = cell_addr(ROW_W'(r_start_row), COL_W'(r_start_col));
            end
            S_START_CHK: begin
                if (start_open) begin
                    n_top.row = ROW_W'(r_start_row);
                    n_top.col = COL_W'(r_start_col);
                    n_top.dir = DIR_UP;
                    n_fill    = FILL_W'(1);
                    grid_we   = 1'b1;
                    grid_wa   = cell_addr(ROW_W'(r_start_row), COL_W'(r_start_col));
                    grid_wd   = CELL_PATH;
                end
            end
            S_EXAMINE: begin
                if (at_exit) begin
                    // Reaching the exit counts one path; the first shortest one wins ties.
                    n_paths = paths_inc;
                    if (r_fill < r_best_len) begin
                        n_best_len   = r_fill;
                        n_best_order = paths_inc;
                    end
                end else if (r_top.dir != DIR_DONE) begin
                    n_nb_row  = step_row;
                    n_nb_col  = step_col;
                    n_nb_in   = step_in;
                    n_top.dir = t_dir'(r_top.dir + DIR_W'(1));
                end
            end
            S_NB_CHK: begin
                if (nb_open && stack_room) begin
                    stk_we    = 1'b1;
                    grid_we   = 1'b1;
                    grid_wa   = cell_addr(r_nb_row, r_nb_col);
                    grid_wd   = CELL_PATH;
                    n_top.row = r_nb_row;
                    n_top.col = r_nb_col;
                    n_top.dir = DIR_UP;
                    n_fill    = r_fill + FILL_W'(1);
                end else if (nb_open) begin
                    n_ovf = 1'b1;
                end
            end
            S_POP: begin
                grid_we = 1'b1;
                grid_wd = CELL_OPEN;
                n_fill  = fill_m1;
            end
            S_RESTORE: begin
                n_top = r_stk_rd;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_item.found           = (r_paths != '0);
                    n_out_item.path_count      = r_paths;
                    n_out_item.stack_overflow  = r_ovf;
                    n_out_item.shortest_order  = (r_paths != '0) ? r_best_order : '0;
                    n_out_item.shortest_length = '0;
                    if (r_paths != '0) begin
                        n_out_item.shortest_length = (int'(r_best_len) > LEN_MAX) ?
                            LEN_W'(LEN_MAX) : LEN_W'(r_best_len);
                    end
                end
            end
            default: begin
                grid_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_paths      <= '0;
            r_best_len   <= FILL_W'(STACK_DEPTH + 1);
            r_best_order <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cell_vld   <= '0;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_paths      <= n_paths;
            r_best_len   <= n_best_len;
            r_best_order <= n_best_order;
            r_ovf        <= n_ovf;
            r_out_valid  <= n_out_valid;
            if (grid_we) begin
                r_cell_vld[grid_wa] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_start_row <= n_start_row;
        r_start_col <= n_start_col;
        r_exit_row  <= n_exit_row;
        r_exit_col  <= n_exit_col;
        r_top       <= n_top;
        r_nb_row    <= n_nb_row;
        r_nb_col    <= n_nb_col;
        r_nb_in     <= n_nb_in;
        r_out_item  <= n_out_item;
    end

    // Grid memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (grid_we) begin
            r_grid[grid_wa] <= grid_wd;
        end
        r_rd_data <= r_grid[grid_ra];
        r_rd_vld  <= r_cell_vld[grid_ra];
    end

    // Stack memory: the top frame is pushed down on every advance.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_wa] <= r_top;
        end
        r_stk_rd <= r_stack[stk_ra];
    end

`include "maze_all_paths_search_macros.svh"

    `MAPS_ASSERT(a_fill_bounded, (int'(r_fill) <= STACK_DEPTH), "stack fill beyond depth")
    `MAPS_ASSERT(a_examine_nonempty, ((r_state == S_EXAMINE) |-> (r_fill != '0)), "empty stack examined")
    `MAPS_ASSERT(a_result_from_done, ($rose(r_out_valid) |-> $past(r_state == S_DONE)), "result outside done")
    `MAPS_ASSERT_NEXT(a_push_grows, ((r_state == S_NB_CHK) && stk_we), (r_fill == $past(r_fill) + FILL_W'(1)), "push did not grow stack")

endmodule
